@@ hw/rtl/slt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// shared constants and codes of the sorted list table
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_DELETE    = 2'd1,
		OP_READ_ASC  = 2'd2,
		OP_READ_DESC = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

endpackage

@@ hw/rtl/slt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module slt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/sorted_list_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_table
// bounded table of signed values kept in ascending order
//
// One input transaction carries op and value: insert, delete, read ascending
// or read descending. Insert and delete give one result transaction with
// last set; a read gives one result per stored entry, the final one with
// last set, or a single empty-status result when nothing is stored.
// The entries live in one ram with a registered read. Insert walks down
// from the top entry, moving each larger entry up by one as it goes.
// Delete searches upward and then moves the entries above the hit down by
// one. A read streams one result per cycle while the receiver does not
// stall. The ram port pair allows one read and one write per cycle. One
// item is in work at a time; the next is taken once the current one's last
// result sits in the output register, even while that result still waits.
// When the receiver stalls, the output register holds and a read stream or
// a waiting result pauses; the insert and delete walks run on to their end.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op,
	input  logic signed [slt_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [slt_pkg::DATA_W-1:0] entry,
	output logic [1:0]                        status,
	output logic                              last
);

	import slt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS0,
		S_DSRCH,
		S_DSHIFT,
		S_READ,
		S_RESP
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   rem_q, rem_d;
	logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
	logic               desc_q, desc_d;
	logic [DATA_W-1:0]  value_q, value_d;
	logic [DATA_W-1:0]  rsp_entry_q, rsp_entry_d;
	status_t            rsp_status_q, rsp_status_d;
	logic               out_valid_q, out_valid_d;
	logic [DATA_W-1:0]  out_entry_q, out_entry_d;
	status_t            out_status_q, out_status_d;
	logic               out_last_q, out_last_d;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [DATA_W-1:0]  wr_data;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [DATA_W-1:0]  rd_data;

	logic               ofree;
	logic               last_hit;
	logic               rd_gt;
	logic [CNT_W-1:0]   idx_ext;

	slt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign ofree    = !out_valid_q || out_ready;
	assign idx_ext  = CNT_W'(rd_idx_q);
	assign last_hit = (idx_ext + CNT_W'(1)) == count_q;
	assign rd_gt    = $signed(rd_data) > $signed(value_q);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign entry     = out_entry_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		rem_d        = rem_q;
		desc_d       = desc_q;
		value_d      = value_q;
		rsp_entry_d  = rsp_entry_q;
		rsp_status_d = rsp_status_q;
		out_valid_d  = out_valid_q && !out_ready;
		out_entry_d  = out_entry_q;
		out_status_d = out_status_q;
		out_last_d   = out_last_q;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = value_q;
		rd_en        = 1'b0;
		rd_addr      = rd_idx_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					value_d     = value;
					rsp_entry_d = value;
					case (op)
						OP_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								rsp_status_d = ST_FULL;
								state_d      = S_RESP;
							end else if (count_q == '0) begin
								wr_en        = 1'b1;
								wr_addr      = '0;
								wr_data      = value;
								count_d      = count_q + CNT_W'(1);
								rsp_status_d = ST_OK;
								state_d      = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = IDX_W'(count_q - CNT_W'(1));
								state_d = S_INS;
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								rsp_status_d = ST_NOT_FOUND;
								state_d      = S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = S_DSRCH;
							end
						end
						default: begin
							if (count_q == '0) begin
								rsp_entry_d  = '0;
								rsp_status_d = ST_EMPTY;
								state_d      = S_RESP;
							end else begin
								desc_d  = (op == OP_READ_DESC);
								rem_d   = count_q;
								rd_en   = 1'b1;
								rd_addr = (op == OP_READ_DESC) ?
								          IDX_W'(count_q - CNT_W'(1)) : '0;
								state_d = S_READ;
							end
						end
					endcase
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = rd_idx_q + IDX_W'(1);
				if (rd_gt) begin
					wr_data = rd_data;
					if (rd_idx_q == '0) begin
						state_d = S_INS0;
					end else begin
						rd_en   = 1'b1;
						rd_addr = rd_idx_q - IDX_W'(1);
					end
				end else begin
					wr_data      = value_q;
					count_d      = count_q + CNT_W'(1);
					rsp_status_d = ST_OK;
					state_d      = S_RESP;
				end
			end
			S_INS0: begin
				wr_en        = 1'b1;
				wr_addr      = '0;
				wr_data      = value_q;
				count_d      = count_q + CNT_W'(1);
				rsp_status_d = ST_OK;
				state_d      = S_RESP;
			end
			S_DSRCH: begin
				if (rd_data == value_q) begin
					if (last_hit) begin
						count_d      = count_q - CNT_W'(1);
						rsp_status_d = ST_OK;
						state_d      = S_RESP;
					end else begin
						rd_en   = 1'b1;
						rd_addr = rd_idx_q + IDX_W'(1);
						state_d = S_DSHIFT;
					end
				end else if (rd_gt || last_hit) begin
					rsp_status_d = ST_NOT_FOUND;
					state_d      = S_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_idx_q + IDX_W'(1);
				end
			end
			S_DSHIFT: begin
				wr_en   = 1'b1;
				wr_addr = rd_idx_q - IDX_W'(1);
				wr_data = rd_data;
				if (last_hit) begin
					count_d      = count_q - CNT_W'(1);
					rsp_status_d = ST_OK;
					state_d      = S_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_idx_q + IDX_W'(1);
				end
			end
			S_READ: begin
				if (ofree) begin
					out_valid_d  = 1'b1;
					out_entry_d  = rd_data;
					out_status_d = ST_OK;
					out_last_d   = (rem_q == CNT_W'(1));
					if (rem_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end else begin
						rem_d   = rem_q - CNT_W'(1);
						rd_en   = 1'b1;
						rd_addr = desc_q ? (rd_idx_q - IDX_W'(1)) : (rd_idx_q + IDX_W'(1));
					end
				end
			end
			S_RESP: begin
				if (ofree) begin
					out_valid_d  = 1'b1;
					out_entry_d  = rsp_entry_q;
					out_status_d = rsp_status_q;
					out_last_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		rd_idx_d = rd_en ? rd_addr : rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			out_valid_q  <= out_valid_d;
			rem_q        <= rem_d;
			rd_idx_q     <= rd_idx_d;
			desc_q       <= desc_d;
			value_q      <= value_d;
			rsp_entry_q  <= rsp_entry_d;
			rsp_status_q <= rsp_status_d;
			out_entry_q  <= out_entry_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	// table never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
		      || (count_q + CNT_W'(1) == $past(count_q)))
		else $error("entry count jumped");

	// the walk never reads the entry it writes in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("ram read and write hit the same entry");

	// a read stream always has results left
	a_read_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (rem_q != '0) && (rem_q <= count_q))
		else $error("read stream count out of range");

	// of the accepted transactions, only an insert can change the entry count at once
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (count_q == $past(count_q)) || ($past(op) == OP_INSERT))
		else $error("table changed on a non-insert accept");

endmodule
